@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the color converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk_s, rst_ns, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
		else $error("Same-cycle implication failed.");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_s, rst_ns, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
		else $error("Next-cycle implication failed.");

`endif

@@ hdl/hsvrgb_pkg.sv @@
// Shared constants and types of the HSV to RGB converter.
package hsvrgb_pkg;

	// Field widths.
	localparam int HUE_W  = 16;
	localparam int CHAN_W = 8;
	localparam int PROD_W = 2 * CHAN_W;

	// Full scale of saturation and value.
	localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;

	// One full unit of the 16-bit hue fraction.
	localparam logic [HUE_W:0] FRAC_ONE = 17'h10000;

	// 255 * 65536, the common denominator of the blended channels.
	localparam logic [23:0] DEN_FRAC = 24'd16711680;

	// Hue sector codes.
	typedef enum logic [2:0] {
		SECT_RED_YEL = 3'd0,
		SECT_YEL_GRN = 3'd1,
		SECT_GRN_CYN = 3'd2,
		SECT_CYN_BLU = 3'd3,
		SECT_BLU_MAG = 3'd4,
		SECT_MAG_RED = 3'd5
	} sector_t;

endpackage

@@ hdl/hsvrgb_div255.sv @@
// Two-step division of a 16-bit value by 255 (reciprocal estimate, then correction).
module hsvrgb_div255 import hsvrgb_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [PROD_W-1:0] dividend,
	output logic [CHAN_W-1:0] quotient
);

	logic [PROD_W+CHAN_W:0] scaled;
	logic [CHAN_W-1:0]      est_s4;
	logic [PROD_W-1:0]      dividend_s4;
	logic [PROD_W-1:0]      est_times;
	logic [PROD_W-1:0]      remainder;

	// Estimate x/255 as x*257/65536; it is exact or one too small.
	assign scaled = {1'b0, dividend, {CHAN_W{1'b0}}} + {{(CHAN_W+1){1'b0}}, dividend};

	always_ff @(posedge clk) begin
		if (en) begin
			est_s4      <= scaled[PROD_W+CHAN_W-1:PROD_W];
			dividend_s4 <= dividend;
		end
	end

	// Bump the estimate when the remainder reaches the divisor.
	always_comb begin
		est_times = {est_s4, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, est_s4};
		remainder = dividend_s4 - est_times;
		quotient  = est_s4 + CHAN_W'(remainder >= {{CHAN_W{1'b0}}, CHAN_FULL});
	end

endmodule

@@ hdl/hsv_to_rgb_converter.sv @@
// Throughput: one pixel per cycle while the output is not stalled; the five register stages all advance together.
// A stalled output holds the whole pipeline, so no transaction is lost or repeated.
// Reset clears only the stage valid bits; the pixel data registers are not reset.
// Stages: hue*6, products with S, numerators with V, divide by 255, route by sector.
`include "assert_macros.svh"

module hsv_to_rgb_converter import hsvrgb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hsv_valid,
	output logic              hsv_stall,
	input  logic [HUE_W-1:0]  hue,
	input  logic [CHAN_W-1:0] saturation,
	input  logic [CHAN_W-1:0] value,
	output logic              rgb_valid,
	input  logic              rgb_stall,
	output logic [CHAN_W-1:0] red,
	output logic [CHAN_W-1:0] green,
	output logic [CHAN_W-1:0] blue
);

	logic              adv;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [HUE_W+2:0]  hue6;
	logic [2:0]        sector_s1, sector_s2, sector_s3, sector_s4;
	logic [HUE_W-1:0]  frac_s1;
	logic [CHAN_W-1:0] sat_s1;
	logic [CHAN_W-1:0] val_s1, val_s2, val_s3, val_s4;
	logic [HUE_W:0]    frac_inv;
	logic [23:0]       sq_s2, st_s2;
	logic [PROD_W-1:0] np_s2;
	logic [31:0]       num_q, num_t;
	logic [PROD_W-1:0] xq_s3, xt_s3, xp_s3;
	logic [CHAN_W-1:0] pq, pt, pp;
	logic [CHAN_W-1:0] red_s5, green_s5, blue_s5;

	// The pipeline moves whenever the output register is free or being taken.
	assign adv       = !(v_s5 && rgb_stall);
	assign hsv_stall = !adv;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= hsv_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: scale hue by six, split into sector and fraction.
	assign hue6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s1 <= hue6[HUE_W+2:HUE_W];
			frac_s1   <= hue6[HUE_W-1:0];
			sat_s1    <= saturation;
			val_s1    <= value;
		end
	end

	// Stage 2: saturation times the fraction and its complement, and V*(1-S).
	assign frac_inv = FRAC_ONE - {1'b0, frac_s1};

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s2     <= 24'({16'd0, sat_s1} * {8'd0, frac_s1});
			st_s2     <= 24'({17'd0, sat_s1} * {8'd0, frac_inv});
			np_s2     <= {{CHAN_W{1'b0}}, val_s1} * {{CHAN_W{1'b0}}, CHAN_FULL - sat_s1};
			sector_s2 <= sector_s1;
			val_s2    <= val_s1;
		end
	end

	// Stage 3: value times the blended numerators, keep the part above 2^16.
	assign num_q = {24'd0, val_s2} * {8'd0, DEN_FRAC - sq_s2};
	assign num_t = {24'd0, val_s2} * {8'd0, DEN_FRAC - st_s2};

	always_ff @(posedge clk) begin
		if (adv) begin
			xq_s3     <= num_q[31:16];
			xt_s3     <= num_t[31:16];
			xp_s3     <= np_s2;
			sector_s3 <= sector_s2;
			val_s3    <= val_s2;
		end
	end

	// Stage 4: divide each intermediate by 255.
	hsvrgb_div255 u_div_q (.clk(clk), .en(adv), .dividend(xq_s3), .quotient(pq));
	hsvrgb_div255 u_div_t (.clk(clk), .en(adv), .dividend(xt_s3), .quotient(pt));
	hsvrgb_div255 u_div_p (.clk(clk), .en(adv), .dividend(xp_s3), .quotient(pp));

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s4 <= sector_s3;
			val_s4    <= val_s3;
		end
	end

	// Stage 5: route the intermediates to the channels by sector.
	always_ff @(posedge clk) begin
		if (adv) begin
			unique case (sector_t'(sector_s4))
				SECT_RED_YEL: begin
					red_s5 <= val_s4; green_s5 <= pt;     blue_s5 <= pp;
				end
				SECT_YEL_GRN: begin
					red_s5 <= pq;     green_s5 <= val_s4; blue_s5 <= pp;
				end
				SECT_GRN_CYN: begin
					red_s5 <= pp;     green_s5 <= val_s4; blue_s5 <= pt;
				end
				SECT_CYN_BLU: begin
					red_s5 <= pp;     green_s5 <= pq;     blue_s5 <= val_s4;
				end
				SECT_BLU_MAG: begin
					red_s5 <= pt;     green_s5 <= pp;     blue_s5 <= val_s4;
				end
				default: begin
					red_s5 <= val_s4; green_s5 <= pp;     blue_s5 <= pq;
				end
			endcase
		end
	end

	assign rgb_valid = v_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;

	// An accepted transaction always lands in stage 1.
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, hsv_valid && !hsv_stall, v_s1)
	// Input backpressure only comes from a held output.
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, hsv_stall, rgb_valid && rgb_stall)
	// Hue times six never yields a sector beyond the last one.
	`ASSERT_IMPLIES(a_sector_range, clk, arst_n, v_s1, sector_s1 <= 3'(SECT_MAG_RED))

endmodule
